// ----- design/ipv_pkg.sv -----
package ipv_pkg;

    localparam logic [1:0] VERDICT_V4   = 2'd0;
    localparam logic [1:0] VERDICT_V6   = 2'd1;
    localparam logic [1:0] VERDICT_NONE = 2'd2;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;

    localparam logic [9:0] V4_FIELD_MAX = 10'd255;
    localparam logic [1:0] V4_DOTS      = 2'd3;
    localparam logic [1:0] V4_DIGITS    = 2'd3;
    localparam logic [2:0] V6_COLONS    = 3'd7;
    localparam logic [2:0] V6_DIGITS    = 3'd4;

    typedef struct packed {
        logic       v4_alive;
        logic [1:0] v4_fields;
        logic [1:0] v4_digits;
        logic [9:0] v4_value;
        logic       v6_alive;
        logic [2:0] v6_groups;
        logic [2:0] v6_digits;
    } trk_state_t;

    localparam trk_state_t TRK_RESET = '{
        v4_alive:  1'b1,
        v4_fields: 2'd0,
        v4_digits: 2'd0,
        v4_value:  10'd0,
        v6_alive:  1'b1,
        v6_groups: 3'd0,
        v6_digits: 3'd0
    };

endpackage

// ----- design/ip_address_text_validator_top.sv -----
// A verdict reaches the master side through the input register and then the result register.
// Throughput: one character per cycle; the input register and the result register are
// separate stages, so characters keep flowing while a verdict waits to be taken.
// A last character stalls only while the previous verdict still sits unread.
// Reset (rst_n low, asynchronous): both trackers return to their start state, all valid flags clear.
module ip_address_text_validator_top
    import ipv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] verdict, [7:2] zero
);

    // Input register: one character and its end-of-string flag.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Tracker state, updated once per character leaving the input register.
    trk_state_t state_reg;
    trk_state_t state_next;
    trk_state_t state_upd;
    logic [1:0] step_verdict;

    // Result register.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] out_verdict_reg;

    logic       in_take;
    logic       step_go;
    logic       out_load;

    ipv_track u_track (
        .cur       (state_reg),
        .char_code (in_char_reg),
        .upd       (state_upd),
        .verdict   (step_verdict)
    );

    // Advance the held character unless it would produce a verdict while the result
    // register is still full and not being drained this cycle.
    assign step_go  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign out_load = step_go && in_last_reg;

    assign s_axis_tready = !in_valid_reg || step_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !step_go);

        // End of string: drop back to the start state for the next address.
        state_next = state_reg;
        if (step_go)
            state_next = in_last_reg ? TRK_RESET : state_upd;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= TRK_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: hold while stalled, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (out_load)
            out_verdict_reg <= step_verdict;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_verdict_reg};

`ifndef SYNTH
    // A verdict only appears after a last character has left the input register.
    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("verdict raised without a last character");

    // Trackers restart cleanly after every string.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && in_last_reg) |=> (state_reg == TRK_RESET))
        else $error("tracker state not cleared after end of string");

    // Never emit an unused verdict code.
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_verdict_reg != 2'd3))
        else $error("illegal verdict code");

    // An IPv4 field with no digits always carries a zero value.
    a_v4_empty_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.v4_digits == 2'd0) |-> (state_reg.v4_value == 10'd0))
        else $error("IPv4 field value without digits");
`endif

endmodule

// ----- design/ipv_track.sv -----
// One character step of both trackers, plus the verdict on the updated state.
module ipv_track
    import ipv_pkg::*;
(
    input  trk_state_t cur,
    input  logic [7:0] char_code,
    output trk_state_t upd,
    output logic [1:0] verdict
);

    logic       is_dec;
    logic       is_hex;
    logic [9:0] times_ten;
    logic [9:0] digit_val;
    logic       v4_ok;
    logic       v6_ok;

    always_comb
    begin
        is_dec    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_hex    = is_dec
                    || ((char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_F))
                    || ((char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F));
        times_ten = {cur.v4_value[6:0], 3'b000} + {cur.v4_value[8:0], 1'b0};
        digit_val = {6'd0, char_code[3:0]};
        upd       = cur;

        if (cur.v4_alive)
        begin
            priority if (is_dec)
            begin
                if ((cur.v4_digits == 2'd0) && (char_code == CHAR_ZERO))
                    upd.v4_alive = 1'b0;
                else if (cur.v4_digits == V4_DIGITS)
                    upd.v4_alive = 1'b0;
                else
                begin
                    upd.v4_value  = times_ten + digit_val;
                    upd.v4_digits = cur.v4_digits + 2'd1;
                end
            end
            else if (char_code == CHAR_DOT)
            begin
                if ((cur.v4_digits == 2'd0) || (cur.v4_value > V4_FIELD_MAX)
                    || (cur.v4_fields == V4_DOTS))
                    upd.v4_alive = 1'b0;
                else
                begin
                    upd.v4_fields = cur.v4_fields + 2'd1;
                    upd.v4_digits = 2'd0;
                    upd.v4_value  = 10'd0;
                end
            end
            else
                upd.v4_alive = 1'b0;
        end

        if (cur.v6_alive)
        begin
            priority if (is_hex)
            begin
                if (cur.v6_digits == V6_DIGITS)
                    upd.v6_alive = 1'b0;
                else
                    upd.v6_digits = cur.v6_digits + 3'd1;
            end
            else if (char_code == CHAR_COLON)
            begin
                if ((cur.v6_digits == 3'd0) || (cur.v6_groups == V6_COLONS))
                    upd.v6_alive = 1'b0;
                else
                begin
                    upd.v6_groups = cur.v6_groups + 3'd1;
                    upd.v6_digits = 3'd0;
                end
            end
            else
                upd.v6_alive = 1'b0;
        end

        v4_ok = upd.v4_alive && (upd.v4_fields == V4_DOTS) && (upd.v4_digits != 2'd0)
                && (upd.v4_value <= V4_FIELD_MAX);
        v6_ok = upd.v6_alive && (upd.v6_groups == V6_COLONS) && (upd.v6_digits != 3'd0);

        priority if (v6_ok)
            verdict = VERDICT_V6;
        else if (v4_ok)
            verdict = VERDICT_V4;
        else
            verdict = VERDICT_NONE;
    end

endmodule
